>>> rtl/periodic_timer_bank_round_robin_unit_assert.svh
// assertion macros for the periodic timer bank
`ifndef PERIODIC_TIMER_BANK_ROUND_ROBIN_UNIT_ASSERT_SVH
`define PERIODIC_TIMER_BANK_ROUND_ROBIN_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PTB_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PTB_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`endif

>>> rtl/ptb_pkg.sv
// shared types and constants of the periodic timer bank
`default_nettype none

package ptb_pkg;

  localparam int KIND_W   = 3;
  localparam int SLOT_W   = 5;
  localparam int PERIOD_W = 16;

  // request stream layout
  localparam int S_TDATA_W   = 24;
  localparam int TD_IDX_LO   = 0;
  localparam int TD_PER_LO   = TD_IDX_LO + SLOT_W;
  localparam int TD_REP_BIT  = TD_PER_LO + PERIOD_W;
  localparam int M_TDATA_W   = 8;

  // request kinds as they arrive on tuser
  localparam logic [KIND_W-1:0] KIND_ADD     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CHANGE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOP    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_START   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SERVICE = 3'd5;

  // remainder unit: 17-bit dividend, one quotient bit per cycle
  localparam logic [4:0] MOD_LAST_STEP = 5'd16;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_CHANGE,
    OP_STOP,
    OP_START,
    OP_TICK,
    OP_SERVICE,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [SLOT_W-1:0]   index;
    logic [PERIOD_W-1:0] period;
    logic                repeat_mode;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic idle;
    logic full;
  } bk_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADD_SCAN,
    ST_MOD,
    ST_ADD_WRITE,
    ST_TICK,
    ST_SERVICE,
    ST_RESULT
  } st_e;

endpackage

`default_nettype wire

>>> rtl/ptb_front.sv
// request intake: decodes the kind field into an operation for the queue
`default_nettype none

module ptb_front (
  input  wire logic                             s_tvalid_i,
  output logic                                  s_tready_o,
  input  wire logic [ptb_pkg::S_TDATA_W-1:0]    s_tdata_i,
  input  wire logic [ptb_pkg::KIND_W-1:0]       s_tuser_i,
  input  wire ptb_pkg::q_stat_t                 q_stat_i,
  output logic                                  push_o,
  output ptb_pkg::cmd_t                         cmd_o
);

  ptb_pkg::op_e op;

  // kind decode, unused codes become a no-op
  always_comb begin
    case (s_tuser_i)
      ptb_pkg::KIND_ADD:     op = ptb_pkg::OP_ADD;
      ptb_pkg::KIND_CHANGE:  op = ptb_pkg::OP_CHANGE;
      ptb_pkg::KIND_STOP:    op = ptb_pkg::OP_STOP;
      ptb_pkg::KIND_START:   op = ptb_pkg::OP_START;
      ptb_pkg::KIND_TICK:    op = ptb_pkg::OP_TICK;
      ptb_pkg::KIND_SERVICE: op = ptb_pkg::OP_SERVICE;
      default:               op = ptb_pkg::OP_NONE;
    endcase
  end

  // unpack fields
  always_comb begin
    cmd_o.op          = op;
    cmd_o.index       = s_tdata_i[ptb_pkg::TD_IDX_LO +: ptb_pkg::SLOT_W];
    cmd_o.period      = s_tdata_i[ptb_pkg::TD_PER_LO +: ptb_pkg::PERIOD_W];
    cmd_o.repeat_mode = s_tdata_i[ptb_pkg::TD_REP_BIT];
  end

  // take a request whenever the queue has room
  assign s_tready_o = !q_stat_i.full;
  assign push_o     = s_tvalid_i && !q_stat_i.full;

endmodule

`default_nettype wire

>>> rtl/ptb_queue.sv
// two-entry command queue between intake and execution
`default_nettype none

module ptb_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ptb_pkg::cmd_t     cmd_i,
  input  wire logic              pop_i,
  output ptb_pkg::cmd_t          cmd_o,
  output ptb_pkg::q_stat_t       stat_o
);

  ptb_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign do_push = push_i && (cnt_q != 2'd2);
  assign do_pop  = pop_i && (cnt_q != 2'd0);

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o        = entry_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

endmodule

`default_nettype wire

>>> rtl/ptb_back.sv
// execution sequencer: timer storage, tick walk, add alignment, round-robin service
`default_nettype none

module ptb_back #(
  parameter int NUM_TIMERS = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cmd_valid_i,
  input  wire ptb_pkg::cmd_t                  cmd_i,
  output logic                                cmd_pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [ptb_pkg::SLOT_W-1:0]          out_slot_o,
  output logic                                out_ok_o,
  output ptb_pkg::bk_stat_t                   stat_o
);

  localparam int IW   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW   = $clog2(NUM_TIMERS + 1);
  localparam int SW   = ptb_pkg::SLOT_W;
  localparam int PW   = ptb_pkg::PERIOD_W;
  localparam int CMPW = (CW > SW) ? CW : SW;
  localparam logic [CW-1:0] NumTimers = CW'(NUM_TIMERS);

  ptb_pkg::st_e         state_q, state_d;
  ptb_pkg::cmd_t        cmd_q, cmd_d;
  logic [CW-1:0]        used_q, used_d;
  logic [IW-1:0]        ls_q, ls_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [IW-1:0]        rd_addr_q, rd_addr_d;
  logic                 match_q, match_d;
  logic [PW:0]          num_q, num_d;
  logic [PW:0]          rem_q, rem_d;
  logic [4:0]           step_q, step_d;
  logic [PW-1:0]        start_q, start_d;
  logic [NUM_TIMERS-1:0] running_q, running_d;
  logic [NUM_TIMERS-1:0] repeating_q, repeating_d;
  logic [NUM_TIMERS-1:0] pending_q, pending_d;
  logic [SW-1:0]        res_slot_q, res_slot_d;
  logic                 res_ok_q, res_ok_d;
  logic                 out_vld_q, out_vld_d;
  logic [SW-1:0]        out_slot_q, out_slot_d;
  logic                 out_ok_q, out_ok_d;

  // counter and period storage
  logic [PW-1:0]        tick_mem [NUM_TIMERS];
  logic [PW-1:0]        per_mem  [NUM_TIMERS];
  logic [PW-1:0]        tick_rd_q, per_rd_q;
  logic                 tick_we, per_we, rd_en;
  logic [IW-1:0]        waddr;
  logic [PW-1:0]        tick_wdata, per_wdata;

  // derived values
  logic [IW+SW-1:0]     idx_ext;
  logic [IW-1:0]        cmd_addr;
  logic [SW+CW-1:0]     used_ext;
  logic [IW+CW-1:0]     used_aext;
  logic [IW-1:0]        used_addr;
  logic                 idx_valid;
  logic                 bank_full;
  logic                 issuing;
  logic [CW-1:0]        ls_inc;
  logic [IW-1:0]        ls_nxt;
  logic [SW+IW-1:0]     ls_ext;
  logic [PW-1:0]        t_inc;
  logic                 t_hit;
  logic [PW:0]          rem_sh;
  logic [PW:0]          rem_next;
  logic                 svc_last;
  logic                 out_free;

  assign idx_ext   = {{IW{1'b0}}, cmd_q.index};
  assign cmd_addr  = idx_ext[IW-1:0];
  assign used_ext  = {{SW{1'b0}}, used_q};
  assign used_aext = {{IW{1'b0}}, used_q};
  assign used_addr = used_aext[IW-1:0];
  assign idx_valid = CMPW'(cmd_q.index) < CMPW'(used_q);
  assign bank_full = (used_q == NumTimers);
  assign issuing   = (idx_q < used_q);

  // round-robin pointer step, wrapping at the number of slots in use
  assign ls_inc   = CW'(ls_q) + CW'(1);
  assign ls_nxt   = (ls_inc == used_q) ? '0 : ls_inc[IW-1:0];
  assign ls_ext   = {{SW{1'b0}}, ls_nxt};
  assign svc_last = ((idx_q + CW'(1)) == used_q);

  // tick update of one entry
  assign t_inc = tick_rd_q + PW'(1);
  assign t_hit = (t_inc == per_rd_q);

  // restoring remainder step
  assign rem_sh   = {rem_q[PW-1:0], num_q[PW]};
  assign rem_next = (rem_sh >= {1'b0, cmd_q.period}) ? rem_sh - {1'b0, cmd_q.period} : rem_sh;

  assign out_free = !out_vld_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ptb_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = ptb_pkg::ST_DISPATCH;
        end
      end
      ptb_pkg::ST_DISPATCH: begin
        case (cmd_q.op)
          ptb_pkg::OP_ADD: begin
            if (bank_full) begin
              state_d = ptb_pkg::ST_RESULT;
            end else if (used_q == '0 || cmd_q.period == '0) begin
              state_d = ptb_pkg::ST_ADD_WRITE;
            end else begin
              state_d = ptb_pkg::ST_ADD_SCAN;
            end
          end
          ptb_pkg::OP_TICK: begin
            state_d = (used_q == '0) ? ptb_pkg::ST_RESULT : ptb_pkg::ST_TICK;
          end
          ptb_pkg::OP_SERVICE: begin
            state_d = (used_q == '0) ? ptb_pkg::ST_RESULT : ptb_pkg::ST_SERVICE;
          end
          default: begin
            state_d = ptb_pkg::ST_RESULT;
          end
        endcase
      end
      ptb_pkg::ST_ADD_SCAN: begin
        if (!issuing && !rd_vld_q) begin
          state_d = match_q ? ptb_pkg::ST_MOD : ptb_pkg::ST_ADD_WRITE;
        end
      end
      ptb_pkg::ST_MOD: begin
        if (step_q == ptb_pkg::MOD_LAST_STEP) begin
          state_d = ptb_pkg::ST_ADD_WRITE;
        end
      end
      ptb_pkg::ST_ADD_WRITE: begin
        state_d = ptb_pkg::ST_RESULT;
      end
      ptb_pkg::ST_TICK: begin
        if (!issuing && !rd_vld_q) begin
          state_d = ptb_pkg::ST_RESULT;
        end
      end
      ptb_pkg::ST_SERVICE: begin
        if (pending_q[ls_nxt] || svc_last) begin
          state_d = ptb_pkg::ST_RESULT;
        end
      end
      ptb_pkg::ST_RESULT: begin
        if (out_free) begin
          state_d = ptb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ptb_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and storage controls per state
  always_comb begin
    cmd_d       = cmd_q;
    used_d      = used_q;
    ls_d        = ls_q;
    idx_d       = idx_q;
    rd_vld_d    = 1'b0;
    rd_addr_d   = rd_addr_q;
    match_d     = match_q;
    num_d       = num_q;
    rem_d       = rem_q;
    step_d      = step_q;
    start_d     = start_q;
    running_d   = running_q;
    repeating_d = repeating_q;
    pending_d   = pending_q;
    res_slot_d  = res_slot_q;
    res_ok_d    = res_ok_q;
    out_vld_d   = out_vld_q;
    out_slot_d  = out_slot_q;
    out_ok_d    = out_ok_q;
    cmd_pop_o   = 1'b0;
    tick_we     = 1'b0;
    per_we      = 1'b0;
    rd_en       = 1'b0;
    waddr       = cmd_addr;
    tick_wdata  = '0;
    per_wdata   = cmd_q.period;

    // result register drains independently of the sequencer
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ptb_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
        end
      end
      ptb_pkg::ST_DISPATCH: begin
        res_slot_d = '0;
        res_ok_d   = 1'b0;
        idx_d      = '0;
        match_d    = 1'b0;
        start_d    = cmd_q.period - PW'(1);
        case (cmd_q.op)
          ptb_pkg::OP_CHANGE: begin
            res_slot_d = cmd_q.index;
            res_ok_d   = idx_valid;
            tick_we    = idx_valid;
            per_we     = idx_valid;
          end
          ptb_pkg::OP_STOP: begin
            res_slot_d = cmd_q.index;
            res_ok_d   = idx_valid;
            if (idx_valid) begin
              running_d[cmd_addr] = 1'b0;
            end
          end
          ptb_pkg::OP_START: begin
            res_slot_d = cmd_q.index;
            res_ok_d   = idx_valid;
            tick_we    = idx_valid;
            if (idx_valid) begin
              running_d[cmd_addr] = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ptb_pkg::ST_ADD_SCAN: begin
        // walk earlier slots, keep the counter of the last one with this period
        if (issuing) begin
          rd_en     = 1'b1;
          rd_vld_d  = 1'b1;
          rd_addr_d = idx_q[IW-1:0];
          idx_d     = idx_q + CW'(1);
        end
        if (rd_vld_q && per_rd_q == cmd_q.period) begin
          match_d = 1'b1;
          num_d   = {1'b0, tick_rd_q} + (PW+1)'(1);
          rem_d   = '0;
          step_d  = '0;
        end
      end
      ptb_pkg::ST_MOD: begin
        rem_d   = rem_next;
        num_d   = {num_q[PW-1:0], 1'b0};
        step_d  = step_q + 5'd1;
        start_d = rem_next[PW-1:0];
      end
      ptb_pkg::ST_ADD_WRITE: begin
        tick_we                = 1'b1;
        per_we                 = 1'b1;
        waddr                  = used_addr;
        tick_wdata             = start_q;
        running_d[used_addr]   = cmd_q.repeat_mode;
        repeating_d[used_addr] = cmd_q.repeat_mode;
        pending_d[used_addr]   = 1'b0;
        used_d                 = used_q + CW'(1);
        res_slot_d             = used_ext[SW-1:0];
        res_ok_d               = 1'b1;
      end
      ptb_pkg::ST_TICK: begin
        // read one entry per cycle, write back each running entry once its registered read returns
        if (issuing) begin
          rd_en     = 1'b1;
          rd_vld_d  = 1'b1;
          rd_addr_d = idx_q[IW-1:0];
          idx_d     = idx_q + CW'(1);
        end
        waddr = rd_addr_q;
        if (rd_vld_q && running_q[rd_addr_q]) begin
          tick_we    = 1'b1;
          tick_wdata = t_inc;
          if (t_hit) begin
            pending_d[rd_addr_q] = 1'b1;
            if (repeating_q[rd_addr_q]) begin
              tick_wdata = '0;
            end else begin
              running_d[rd_addr_q] = 1'b0;
            end
          end
        end
      end
      ptb_pkg::ST_SERVICE: begin
        ls_d  = ls_nxt;
        idx_d = idx_q + CW'(1);
        if (pending_q[ls_nxt]) begin
          pending_d[ls_nxt] = 1'b0;
          res_slot_d        = ls_ext[SW-1:0];
          res_ok_d          = 1'b1;
        end
      end
      ptb_pkg::ST_RESULT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_slot_d = res_slot_q;
          out_ok_d   = res_ok_q;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptb_pkg::ST_IDLE;
      used_q      <= '0;
      ls_q        <= '0;
      rd_vld_q    <= 1'b0;
      running_q   <= '0;
      repeating_q <= '0;
      pending_q   <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      ls_q        <= ls_d;
      rd_vld_q    <= rd_vld_d;
      running_q   <= running_d;
      repeating_q <= repeating_d;
      pending_q   <= pending_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    idx_q      <= idx_d;
    rd_addr_q  <= rd_addr_d;
    match_q    <= match_d;
    num_q      <= num_d;
    rem_q      <= rem_d;
    step_q     <= step_d;
    start_q    <= start_d;
    res_slot_q <= res_slot_d;
    res_ok_q   <= res_ok_d;
    out_slot_q <= out_slot_d;
    out_ok_q   <= out_ok_d;
  end

  // counter and period memories, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (tick_we) begin
      tick_mem[waddr] <= tick_wdata;
    end
    if (per_we) begin
      per_mem[waddr] <= per_wdata;
    end
    if (rd_en) begin
      tick_rd_q <= tick_mem[idx_q[IW-1:0]];
      per_rd_q  <= per_mem[idx_q[IW-1:0]];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_slot_o  = out_slot_q;
  assign out_ok_o    = out_ok_q;
  assign stat_o.idle = (state_q == ptb_pkg::ST_IDLE);
  assign stat_o.full = bank_full;

endmodule

`default_nettype wire

>>> rtl/periodic_timer_bank_round_robin_unit.sv
// flow: IDLE pops the head; stop, start, change, unused kinds and a full add are done in DISPATCH;
// tick walks the slots in use in TICK; add runs ADD_SCAN unless the bank is empty or the period 0,
// the remainder unit in MOD when an earlier slot shares the period, then ADD_WRITE; walks take one
// slot per cycle; service seeks the next pending slot round robin; each then ends in RESULT
// one request runs at a time; a two-entry queue buffers; a full result register holds the sequencer
// reset: asynchronous, active low; clears flags, slot count, round-robin pointer and handshakes
`default_nettype none

`include "periodic_timer_bank_round_robin_unit_assert.svh"

module periodic_timer_bank_round_robin_unit #(
  parameter int NUM_TIMERS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // index [4:0], period [20:5], repeat_mode [21], zero [23:22]
  input  wire logic [ptb_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // kind [2:0]
  input  wire logic [ptb_pkg::KIND_W-1:0]    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // slot [4:0], zero [7:5]
  output logic [ptb_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // ok [0]
  output logic                               m_axis_tuser
);

  ptb_pkg::cmd_t     front_cmd;
  ptb_pkg::cmd_t     head_cmd;
  ptb_pkg::q_stat_t  q_stat;
  ptb_pkg::bk_stat_t bk_stat;
  logic              push;
  logic              pop;
  logic [ptb_pkg::SLOT_W-1:0] res_slot;
  logic              res_ok;
  logic              out_hs;
  logic              head_wait;

  // request intake
  ptb_front u_front (
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  // decoupling queue
  ptb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (q_stat)
  );

  // execution
  ptb_back #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_stat.empty),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_slot_o  (res_slot),
    .out_ok_o    (res_ok),
    .stat_o      (bk_stat)
  );

  // result packing
  assign m_axis_tdata = {{(ptb_pkg::M_TDATA_W - ptb_pkg::SLOT_W){1'b0}}, res_slot};
  assign m_axis_tuser = res_ok;

  // check terms
  assign out_hs    = m_axis_tvalid && m_axis_tready;
  assign head_wait = bk_stat.idle && !q_stat.empty;

  // checks
  `PTB_ASSERT_NXT(a_out_drains_when_idle, out_hs && bk_stat.idle, !m_axis_tvalid, "idle reload")
  `PTB_ASSERT_NXT(a_idle_takes_head, head_wait, !bk_stat.idle, "queued request not taken")
  `PTB_ASSERT_NXT(a_full_sticky, bk_stat.full, bk_stat.full, "slot count dropped when full")

endmodule

`default_nettype wire
